/* hdl/lru_key_value_cache_top_defines.svh */
// assertion macros for the lru key-value cache
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property checked on every edge outside reset
`define KVC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked on every edge, reset included
`define KVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KVC_ASSERT(lbl, clk, rst, prop, msg)
`define KVC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/lru_kvc_pkg.sv */
// shared constants and types of the lru key-value cache
package lru_kvc_pkg;
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int DATA_W  = 32;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_SET = 1'b1
   } op_type;

   // outcome of one lookup in the tag store
   typedef struct packed {
      logic             hit;
      logic             evict;
      logic [IDX_W-1:0] slot;
   } lookup_type;
endpackage

/* hdl/lru_kvc_req_if.sv */
// request channel: operation, key and value
interface lru_kvc_req_if;
   import lru_kvc_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [DATA_W-1:0] key;
   logic [DATA_W-1:0] value;
   modport source (output valid, output op, output key, output value, input ready);
   modport sink (input valid, input op, input key, input value, output ready);
endinterface

/* hdl/lru_kvc_rsp_if.sv */
// response channel: hit, read value and eviction flag
interface lru_kvc_rsp_if;
   import lru_kvc_pkg::*;
   logic              valid;
   logic              ready;
   logic              hit;
   logic [DATA_W-1:0] read_value;
   logic              evicted;
   modport source (output valid, output hit, output read_value, output evicted, input ready);
   modport sink (input valid, input hit, input read_value, input evicted, output ready);
endinterface

/* hdl/lru_kvc_ram.sv */
// generic single-port ram with registered read
module lru_kvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                         wdata,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read one word
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;
endmodule

/* hdl/lru_kvc_tags.sv */
// key, valid and recency rank store with parallel key compare
`include "lru_key_value_cache_top_defines.svh"
module lru_kvc_tags import lru_kvc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [CAP_W-1:0]  capacity,
   input  logic              op,
   input  logic [DATA_W-1:0] key,
   input  logic              upd_en,
   output lookup_type        res
);
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [DATA_W-1:0]  key_ff [ENTRIES];
   logic [IDX_W-1:0]   rank_ff [ENTRIES];
   logic [IDX_W-1:0]   rank_in [ENTRIES];
   logic [CNT_W-1:0]   occ_ff, occ_in;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] victim;
   logic [IDX_W-1:0]   hit_idx, victim_idx, free_idx;
   logic [CNT_W-1:0]   occ_m1, ref_rank;
   logic [31:0]        eff_cap;
   logic               full, touch;

   // clamp capacity into 1..ENTRIES
   always_comb begin
      eff_cap = 32'(capacity);
      if (eff_cap < 32'd1) eff_cap = 32'd1;
      if (eff_cap > 32'(ENTRIES)) eff_cap = 32'(ENTRIES);
   end

   assign occ_m1 = occ_ff - CNT_W'(1);
   assign full   = 32'(occ_ff) >= eff_cap;

   // compare all keys, find victim (oldest rank) and first free slot
   always_comb begin
      hit_idx    = '0;
      victim_idx = '0;
      free_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         match[i]  = valid_ff[i] && (key_ff[i] == key);
         victim[i] = valid_ff[i] && (CNT_W'(rank_ff[i]) == occ_m1);
         if (match[i]) hit_idx = IDX_W'(i);
         if (victim[i]) victim_idx = IDX_W'(i);
         if (!valid_ff[i]) free_idx = IDX_W'(i);
      end
   end

   // select slot and the rank below which entries age
   always_comb begin
      res.hit   = |match;
      res.evict = !res.hit && (op == OP_SET) && full;
      if (res.hit) begin
         res.slot = hit_idx;
         ref_rank = CNT_W'(rank_ff[hit_idx]);
      end else if (full) begin
         res.slot = victim_idx;
         ref_rank = occ_m1;
      end else begin
         res.slot = free_idx;
         ref_rank = occ_ff;
      end
      touch = res.hit || (op == OP_SET);
   end

   // next ranks, valid bits and occupancy
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (IDX_W'(i) == res.slot) begin
            rank_in[i]  = '0;
            valid_in[i] = 1'b1;
         end else if (valid_ff[i] && (CNT_W'(rank_ff[i]) < ref_rank)) begin
            rank_in[i] = rank_ff[i] + IDX_W'(1);
         end
      end
      if (!res.hit && !full) occ_in = occ_ff + CNT_W'(1);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else if (upd_en && touch) begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= rank_in[i];
      end
   end

   // key of a newly inserted entry
   always_ff @(posedge clock) begin
      if (upd_en && (op == OP_SET) && !res.hit) begin
         key_ff[res.slot] <= key;
      end
   end

   `KVC_ASSERT(a_occ_range, clock, reset, occ_ff <= CNT_W'(ENTRIES), "occupancy above entries")
   `KVC_ASSERT(a_one_match, clock, reset, $onehot0(match), "key stored in two slots")
   `KVC_ASSERT(a_occ_count, clock, reset, $countones(valid_ff) == 32'(occ_ff),
      "occupancy out of step with valid bits")
   `KVC_ASSERT(a_hit_keeps_occ, clock, reset, (upd_en && res.hit) |=> $stable(occ_ff),
      "hit changed occupancy")
endmodule

/* hdl/lru_key_value_cache_top.sv */
// Fully associative LRU key-value cache of ENTRIES slots. A request beat
// carries op (get or set), key and value; each request gives exactly one
// response beat with hit, read_value (stored value on a get hit, else zero)
// and evicted. An item passes S_LOOK (parallel key compare and recency
// update in the tag store, value ram access), then S_DONE (ram read data
// lands in the response register), where the next request is taken while
// the response side keeps up. csr_wdata sets the capacity (clamped to
// 1..16, reset 16); the user must write it only while the cache is idle,
// as the block itself does not enforce this.
`include "lru_key_value_cache_top_defines.svh"
module lru_key_value_cache_top import lru_kvc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   lru_kvc_req_if.sink         req_chan,
   lru_kvc_rsp_if.source       rsp_chan,
   input  logic                csr_we,
   input  logic [CAP_W-1:0]    csr_wdata
);
   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic              op_ff;
   logic [DATA_W-1:0] key_ff, value_ff;
   logic              hit_ff, evict_ff;
   logic              rsp_valid_ff, rsp_hit_ff, rsp_evicted_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   lookup_type        look;
   logic [DATA_W-1:0] ram_rdata;
   logic              can_load, req_beat, in_look, rsp_load;

   assign can_load = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && can_load);
   assign req_beat = req_chan.valid && req_chan.ready;
   assign in_look  = (state_ff == S_LOOK);
   assign rsp_load = (state_ff == S_DONE) && can_load;

   lru_kvc_tags u_tags (
      .clock    (clock),
      .reset    (reset),
      .capacity (cap_ff),
      .op       (op_ff),
      .key      (key_ff),
      .upd_en   (in_look),
      .res      (look)
   );

   // value store: read on get hit, write on set
   lru_kvc_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_values (
      .clock (clock),
      .en    (in_look && (look.hit || (op_ff == OP_SET))),
      .we    (op_ff == OP_SET),
      .addr  (look.slot),
      .wdata (value_ff),
      .rdata (ram_rdata)
   );

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   // request beat capture
   always_ff @(posedge clock) begin
      if (req_beat) begin
         op_ff    <= req_chan.op;
         key_ff   <= req_chan.key;
         value_ff <= req_chan.value;
      end
      if (in_look) begin
         hit_ff   <= look.hit;
         evict_ff <= look.evict;
      end
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response valid: set on load, cleared once the beat is taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_beat) state_ff <= S_LOOK;
            end
            S_LOOK: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (can_load) begin
                  rsp_hit_ff     <= hit_ff;
                  rsp_evicted_ff <= evict_ff;
                  rsp_value_ff   <= (op_ff == OP_GET && hit_ff) ? ram_rdata : '0;
                  state_ff       <= req_beat ? S_LOOK : S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.evicted    = rsp_evicted_ff;

   `KVC_ASSERT(a_look_to_done, clock, reset, (state_ff == S_LOOK) |=> (state_ff == S_DONE),
      "lookup not followed by completion")
   `KVC_ASSERT(a_no_accept_in_look, clock, reset, (state_ff == S_LOOK) |-> !req_chan.ready,
      "request taken during lookup")
   `KVC_ASSERT(a_evict_only_set, clock, reset, (rsp_chan.valid && rsp_chan.evicted) |->
      !rsp_chan.hit, "eviction reported with hit")
endmodule

/* test/lru_key_value_cache_top_tb.sv */
// testbench for the lru key-value cache: directed and random get/set traffic
`timescale 1ns / 1ps
module lru_key_value_cache_top_tb;
   import lru_kvc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CAP_W-1:0] csr_wdata = '0;

   lru_kvc_req_if req_chan();
   lru_kvc_rsp_if rsp_chan();

   lru_key_value_cache_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   typedef struct {
      logic              hit;
      logic [DATA_W-1:0] read_value;
      logic              evicted;
   } result_type;

   // shadow of the cache contents
   logic              shadow_valid [ENTRIES];
   logic [DATA_W-1:0] shadow_key [ENTRIES];
   logic [DATA_W-1:0] shadow_value [ENTRIES];
   int unsigned       shadow_rank [ENTRIES];
   int unsigned       shadow_count;
   logic [CAP_W-1:0]  shadow_capacity;

   result_type pending_results[$];
   logic [DATA_W-1:0] key_pool[$];
   int  error_count = 0;
   longint cycle_count = 0;

   // age every valid slot younger than s, then make s most recent
   function automatic void promote_slot(int s);
      int unsigned r;
      r = shadow_rank[s];
      for (int i = 0; i < ENTRIES; i++)
         if (shadow_valid[i] && i != s && shadow_rank[i] < r) shadow_rank[i]++;
      shadow_rank[s] = 0;
   endfunction

   // expected outcome of one request, updating the shadow
   function automatic result_type predict_lookup(logic op, logic [DATA_W-1:0] key,
                                                 logic [DATA_W-1:0] value);
      result_type res;
      int found, slot, lim;
      int unsigned oldest;
      res = '{1'b0, '0, 1'b0};
      found = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && shadow_valid[i] && shadow_key[i] == key) found = i;
      if (found >= 0) begin
         res.hit = 1'b1;
         if (op == OP_GET) res.read_value = shadow_value[found];
         else shadow_value[found] = value;
         promote_slot(found);
      end else if (op == OP_SET) begin
         slot = -1;
         oldest = 0;
         lim = shadow_capacity;
         if (lim < 1) lim = 1;
         if (lim > ENTRIES) lim = ENTRIES;
         if (shadow_count >= lim) begin
            for (int i = 0; i < ENTRIES; i++)
               if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > oldest)) begin
                  slot = i;
                  oldest = shadow_rank[i];
               end
            if (slot >= 0) begin
               res.evicted = 1'b1;
               shadow_valid[slot] = 1'b0;
               for (int i = 0; i < ENTRIES; i++)
                  if (shadow_valid[i] && shadow_rank[i] > oldest) shadow_rank[i]--;
               shadow_count--;
            end
         end
         if (slot < 0)
            for (int i = ENTRIES - 1; i >= 0; i--)
               if (!shadow_valid[i]) slot = i;
         for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i]) shadow_rank[i]++;
         shadow_valid[slot] = 1'b1;
         shadow_key[slot] = key;
         shadow_value[slot] = value;
         shadow_rank[slot] = 0;
         shadow_count++;
      end
      return res;
   endfunction

   // send one request beat after a random gap; valid stays up with no gap
   task automatic send_request(logic op, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.key   <= key;
      req_chan.value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_results.push_back(predict_lookup(op, key, value));
      if (key_pool.size() < 64) key_pool.push_back(key);
   endtask

   // wait until every response is in, then write the capacity
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_capacity = cap;
      key_pool.delete();
   endtask

   // response stall: new random hold for each beat
   initial begin
      int hold;
      rsp_chan.ready = 1'b0;
      forever begin
         hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   // compare every response beat with the oldest prediction
   always @(posedge clock) begin
      result_type exp;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response hit=%0b rd=%h ev=%0b", $time,
                     rsp_chan.hit, rsp_chan.read_value, rsp_chan.evicted);
            error_count++;
         end else begin
            exp = pending_results.pop_front();
            if (rsp_chan.hit !== exp.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, exp.hit, rsp_chan.hit);
               error_count++;
            end
            if (rsp_chan.read_value !== exp.read_value) begin
               $display("%0t: read_value expected %h actual %h", $time,
                        exp.read_value, rsp_chan.read_value);
               error_count++;
            end
            if (rsp_chan.evicted !== exp.evicted) begin
               $display("%0t: evicted expected %0b actual %0b", $time,
                        exp.evicted, rsp_chan.evicted);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock)
      if (cycle_count > 400000) begin
         $display("TEST FAILED");
         $finish;
      end

   task automatic test_extremes();
      send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_SET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_SET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'h8000_0000, 32'h0);
      send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_GET, 32'h0000_0000, 32'h0);
      send_request(OP_SET, 32'h0000_0000, 32'h1234_5678);
      send_request(OP_GET, 32'h0000_0000, 32'h0);
      send_request(OP_GET, 32'h0000_0001, 32'h0);
   endtask

   // fill past capacity 2, check that get refreshes recency
   task automatic test_eviction();
      write_capacity(5'd2);
      send_request(OP_SET, 32'd1, 32'd10);
      send_request(OP_SET, 32'd2, 32'd20);
      send_request(OP_GET, 32'd1, 32'd0);
      send_request(OP_SET, 32'd3, 32'd30);
      send_request(OP_GET, 32'd2, 32'd0);
      send_request(OP_GET, 32'd1, 32'd0);
      // capacity zero behaves as one, lowered below occupancy
      write_capacity(5'd0);
      send_request(OP_SET, 32'd4, 32'd40);
      send_request(OP_GET, 32'd3, 32'd0);
      send_request(OP_GET, 32'd4, 32'd0);
      // above the number of entries saturates
      write_capacity(5'd31);
   endtask

   // mostly reused keys so hits and evictions are frequent
   task automatic test_random(int count, int key_span);
      logic [DATA_W-1:0] key, value;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 3))
            0: key = $urandom();
            1: key = (key_pool.size() != 0) ?
                     key_pool[$urandom_range(0, key_pool.size() - 1)] : $urandom();
            default: key = $urandom_range(0, key_span);
         endcase
         value = $urandom();
         send_request($urandom_range(0, 1) ? OP_SET : OP_GET, key, value);
      end
   endtask

   initial begin
      logic [CAP_W-1:0] caps [6];
      caps = '{5'd1, 5'd16, 5'd5, 5'd31, 5'd3, 5'd12};
      req_chan.valid = 1'b0;
      req_chan.op    = OP_GET;
      req_chan.key   = '0;
      req_chan.value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
         shadow_rank[i]  = 0;
      end
      shadow_count = 0;
      shadow_capacity = CAP_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_eviction();
      test_random(300, 24);
      foreach (caps[i]) begin
         write_capacity(caps[i]);
         test_random(260, 2 * caps[i] + 2);
      end
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
